FILE: sv/bbf_pkg.sv
// Shared types, constants and helpers for the box blur filter.
package bbf_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_RADIUS = 10;

	localparam int PIXEL_W  = 8;
	localparam int RADIUS_W = 4;
	localparam int DIM_REG_W = 11;
	localparam int CFG_W    = 11;
	localparam int DIM_W    = 14;

	typedef enum logic [1:0] {
		CFG_RADIUS = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2,
		CFG_NONE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WIN,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} bbf_state_t;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = RADIUS_W'(1);
	localparam logic [DIM_REG_W-1:0] DIM_RST = DIM_REG_W'(1024);

	// zero maps to one, oversize saturates at the maximum
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] wv;
		wv = DIM_W'(v);
		if (wv == '0) return DIM_W'(1);
		if (wv > maxv) return maxv;
		return wv;
	endfunction

endpackage

FILE: sv/bbf_ram.sv
// Generic simple dual-port RAM with registered read.
module bbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/box_blur_filter.sv
// Zero-padded box blur over a raster grey pixel stream, top level.
//
//  channel   dir  handshake        payload
//  s_*       in   tvalid/tready    tdata[7:0] = pixel
//  m_*       out  tvalid/tready    tdata[7:0] = smoothed, tlast = last
//  cfg_*     in   we               addr: 0 radius, 1 image_width, 2 image_height
//
// An item that gives no result leaves the block idle. An item that gives a
// result walks its (2r+1)x(2r+1) window one pixel a cycle through the single
// read port of the line store, drains the read, then a restoring divider
// takes one quotient bit a cycle (SW bits, SW = 17 at the default sizes).
// If r exceeds MAX_RADIUS, the width or the height, the walk is skipped.
// Reset clears counters and control only; the line store needs no clearing.
// A new request is taken while the previous result still waits at the output
// register; a stalled output only holds the block at its final step.
module box_blur_filter
	import bbf_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [PIXEL_W-1:0] s_tdata,   // [7:0] pixel
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [PIXEL_W-1:0] m_tdata,   // [7:0] smoothed
	output logic               m_tlast,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	localparam int SLOTS = 2 * MAX_RADIUS + 2;
	localparam int SLW   = $clog2(SLOTS);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 18);
	localparam int RSW   = RW + 1;
	localparam int CSW   = $clog2(MAX_WIDTH + 16) + 1;
	localparam int ICW   = $clog2(MAX_WIDTH * (MAX_HEIGHT + 17));
	localparam int SW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
	localparam int DW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
	localparam int DCW   = $clog2(SW + 1);
	localparam int AW    = SLW + CW;
	localparam int DEPTH = SLOTS * (2 ** CW);

	// configuration
	logic [RADIUS_W-1:0]  radius_q;
	logic [DIM_REG_W-1:0] width_q, height_q;
	logic                 cfg_hit;

	// derived frame geometry
	logic [DIM_W-1:0] w_dim, h_dim;
	logic [WW-1:0]    w;
	logic [HW-1:0]    h;
	logic             zero_all;
	logic [ICW-1:0]   lag;
	logic [5:0]       nslots;

	// input and output position counters
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [SLW-1:0] wslot_q;
	logic [ICW-1:0] in_cnt_q;
	logic [CW-1:0]  ocol_q;
	logic [RW-1:0]  orow_q;
	logic [SLW-1:0] oslot_q;

	// window walk
	bbf_state_t        state_q, state_d;
	logic signed [RSW-1:0] rr_q;
	logic signed [CSW-1:0] cc_q, c0_q;
	logic [SLW-1:0]    slot_q;
	logic [4:0]        dr_q, dc_q, r2;
	logic              rd_s1;
	logic              inb, win_end;
	logic [SW-1:0]     acc_q;
	logic [DW-1:0]     d_q, rem_q;
	logic [DCW-1:0]    div_cnt_q;
	logic              last_q;
	logic [DW:0]       trial;
	logic [5:0]        start_slot;

	logic s_fire, produce, is_last, wr_en, out_load, rd_en, out_free;
	logic [PIXEL_W-1:0] rdata;

	assign cfg_hit = cfg_we && (cfg_idx_t'(cfg_addr) != CFG_NONE);

	assign w_dim = clamp_dim(width_q, DIM_W'(MAX_WIDTH));
	assign h_dim = clamp_dim(height_q, DIM_W'(MAX_HEIGHT));
	assign w = WW'(w_dim);
	assign h = HW'(h_dim);
	assign zero_all = (radius_q > RADIUS_W'(MAX_RADIUS)) || (DIM_W'(radius_q) > w_dim)
		|| (DIM_W'(radius_q) > h_dim);
	assign lag = ICW'(radius_q) * ICW'(w) + ICW'(radius_q);
	assign nslots = {1'b0, radius_q, 1'b0} + 6'd2;
	assign r2 = {radius_q, 1'b0};

	assign s_fire  = s_tvalid && s_tready;
	assign produce = in_cnt_q >= lag;
	assign is_last = produce && (RW'(orow_q) == RW'(h) - RW'(1))
		&& (WW'(ocol_q) == w - WW'(1));
	assign wr_en   = s_fire && !zero_all && (row_q < RW'(h));
	assign out_free = !m_tvalid || m_tready;

	// oldest window row slot: (oslot - r) mod nslots
	assign start_slot = (6'(oslot_q) >= 6'(radius_q)) ? 6'(oslot_q) - 6'(radius_q)
		: 6'(oslot_q) + nslots - 6'(radius_q);

	assign inb = !rr_q[RSW-1] && (rr_q[RW-1:0] < RW'(h))
		&& !cc_q[CSW-1] && (cc_q[CSW-2:0] < (CSW-1)'(w));
	assign win_end = (dr_q == r2) && (dc_q == r2);
	assign trial = {rem_q, acc_q[SW-1]};

	// line store: 2r+2 circular rows, one row per slot
	bbf_ram #(
		.WIDTH(PIXEL_W),
		.DEPTH(DEPTH)
	) u_line (
		.clk  (clk),
		.we   (wr_en),
		.waddr(AW'({wslot_q, col_q})),
		.wdata(s_tdata),
		.re   (rd_en),
		.raddr(AW'({slot_q, cc_q[CW-1:0]})),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_fire && produce) state_d = zero_all ? ST_DIV : ST_WIN;
			end
			ST_WIN: begin
				if (win_end) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCW'(1)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_WIN:   rd_en = 1'b1;
			ST_OUT:   out_load = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			width_q  <= DIM_RST;
			height_q <= DIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_RADIUS: radius_q <= cfg_wdata[RADIUS_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_wdata[DIM_REG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_wdata[DIM_REG_W-1:0];
				CFG_NONE:   ;
			endcase
		end
	end

	// position counters, cleared by cfg_hit or by the frame's last output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			wslot_q  <= '0;
			in_cnt_q <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			oslot_q  <= '0;
		end else if (cfg_hit || (s_fire && is_last)) begin
			col_q    <= '0;
			row_q    <= '0;
			wslot_q  <= '0;
			in_cnt_q <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			oslot_q  <= '0;
		end else if (s_fire) begin
			in_cnt_q <= in_cnt_q + ICW'(1);
			if (WW'(col_q) == w - WW'(1)) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
				wslot_q <= (6'(wslot_q) + 6'd1 == nslots) ? '0 : wslot_q + SLW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
			if (produce) begin
				if (WW'(ocol_q) == w - WW'(1)) begin
					ocol_q <= '0;
					orow_q <= orow_q + RW'(1);
					oslot_q <= (6'(oslot_q) + 6'd1 == nslots) ? '0 : oslot_q + SLW'(1);
				end else begin
					ocol_q <= ocol_q + CW'(1);
				end
			end
		end
	end

	// window walk over rows then columns, one read a cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			rr_q   <= RSW'(orow_q) - RSW'(radius_q);
			cc_q   <= CSW'(ocol_q) - CSW'(radius_q);
			c0_q   <= CSW'(ocol_q) - CSW'(radius_q);
			slot_q <= SLW'(start_slot);
			dr_q   <= '0;
			dc_q   <= '0;
			d_q    <= zero_all ? DW'(1) : DW'(({1'b0, radius_q, 1'b0} + 6'd1)
				* ({1'b0, radius_q, 1'b0} + 6'd1));
			last_q <= is_last;
		end else if (state_q == ST_WIN) begin
			if (dc_q == r2) begin
				dc_q   <= '0;
				cc_q   <= c0_q;
				dr_q   <= dr_q + 5'd1;
				rr_q   <= rr_q + RSW'(1);
				slot_q <= (6'(slot_q) + 6'd1 == nslots) ? '0 : slot_q + SLW'(1);
			end else begin
				dc_q <= dc_q + 5'd1;
				cc_q <= cc_q + CSW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else begin
			rd_s1 <= (state_q == ST_WIN) && inb;
		end
	end

	// accumulate, then restoring division in place (acc becomes the quotient)
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			acc_q     <= '0;
			rem_q     <= '0;
			div_cnt_q <= DCW'(SW);
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q - DCW'(1);
			if (trial >= {1'b0, d_q}) begin
				rem_q <= DW'(trial - {1'b0, d_q});
				acc_q <= {acc_q[SW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				acc_q <= {acc_q[SW-2:0], 1'b0};
			end
		end else if (rd_s1) begin
			acc_q <= acc_q + SW'(rdata);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= acc_q[PIXEL_W-1:0];
			m_tlast <= last_q;
		end
	end

endmodule
